/* design/ffha_pkg.sv */
// Package for the first-fit heap allocator: table sizing, status codes,
// sequencer states and the entry format. Used by the allocator and its checker.
package ffha_pkg;

  localparam int unsigned MaxSegments = 64;
  localparam int unsigned BlockBytes  = 64;
  localparam int unsigned HeaderBytes = 24;
  localparam int unsigned IdxW        = $clog2(MaxSegments);
  localparam int unsigned CntW        = $clog2(MaxSegments + 1);

  // Status codes returned with each result.
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StBadFree = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  // Operation codes.
  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  // Configuration register indexes.
  localparam logic CfgBase  = 1'b0;
  localparam logic CfgLimit = 1'b1;

  // One table entry: header offset, payload size and used flag.
  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic        used;
  } seg_t;

  localparam int unsigned SegW = $bits(seg_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FIX,
    S_NBR_RD,
    S_NBR_CHK,
    S_REM_RD,
    S_REM_WR,
    S_DONE
  } state_e;

endpackage

/* design/ffha_ram.sv */
// Single-port-write, single-port-read segment table memory with a registered
// read port. The entry width is set by the Width parameter.
module ffha_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* design/first_fit_heap_allocator_unit.sv */
// First-fit heap allocator: segment table in one memory, walked by a
// sequencer. Depends on ffha_pkg and ffha_ram.
//
// Usage: requests arrive as beats on the s_axis channel (func in tuser,
// request bytes and release address in tdata). Each request yields one
// result beat on m_axis (granted address and status in tdata).
// Configuration (heap base and limit) is written through cfg_we_i; the
// user must write it only while the block is idle, which the block does
// not enforce. The bounds size the table on the first request after
// reset, and the base offsets every address formed afterwards.
// Sequence: a request scans the table entry by entry, a read state and a
// check state for each. An allocate with a split then shifts the entries
// above it up by one, each with a read and a write. A free shifts the
// entries above it down once for each free neighbor it merges with. The
// table holds at most 64 entries; the single memory port sets this pacing.
// One request is handled at a time; s_axis_tready is low while a request
// is in flight and while its result waits. The result sits in an output
// register until m_axis_tready is seen high; the table is not touched
// while the receiver stalls.
// Reset empties the table (count zero) and restores the default heap
// bounds; the memory itself is not cleared.
module first_fit_heap_allocator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: request_bytes [31:0], release_address [95:32]
  input  logic [95:0]  s_axis_tdata,
  // tuser: func [0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: granted_address [63:0], status [65:64], zero fill [71:66]
  output logic [71:0]  m_axis_tdata
);
  import ffha_pkg::*;

  state_e state_q, state_d;
  logic [63:0] base_q, limit_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic started_q, started_d;
  logic func_q, func_d;
  logic [31:0] want_q, want_d;
  logic [63:0] rel_q, rel_d;
  logic [IdxW-1:0] idx_q, idx_d;   // entry found
  logic [CntW-1:0] ptr_q, ptr_d;   // walking pointer
  seg_t hit_q, hit_d;              // found entry, updated
  seg_t nxt_q, nxt_d;              // split remainder or neighbour entry read
  logic [1:0] phase_q, phase_d;    // free: 0 check right, 1 check left, 2 left merged
  logic [63:0] addr_q, addr_d;
  logic [1:0] st_q, st_d;
  logic ovalid_q, ovalid_d;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  seg_t wdata, rdata;
  logic [SegW-1:0] rdata_raw;

  ffha_ram #(.Depth(MaxSegments), .Width(SegW)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );
  assign rdata = seg_t'(rdata_raw);

  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'd0, st_q, addr_q};

  // Heap span for the initial table, saturated to 32 bits.
  logic [63:0] span64;
  logic [31:0] span;
  always_comb begin
    span64 = (limit_q > base_q) ? (limit_q - base_q) : 64'd0;
    span   = (span64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span64[31:0];
  end

  logic [32:0] want_calc;
  assign want_calc = ({1'b0, s_axis_tdata[31:0]} + 33'(BlockBytes - 1))
                     / 33'(BlockBytes) * 33'(BlockBytes);

  // Helpers for the scan step.
  logic [63:0] paddr;
  logic [31:0] rest;
  assign paddr  = base_q + 64'(rdata.offset) + 64'(HeaderBytes);
  assign rest   = rdata.size - want_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 64'd0;
      limit_q <= 64'd1048576;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgBase:  base_q  <= cfg_data_i;
        CfgLimit: limit_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      started_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    want_q  <= want_d;
    rel_q   <= rel_d;
    idx_q   <= idx_d;
    ptr_q   <= ptr_d;
    hit_q   <= hit_d;
    nxt_q   <= nxt_d;
    phase_q <= phase_d;
    addr_q  <= addr_d;
    st_q    <= st_d;
  end

  // Sequencer: scan, then shift or merge, then present the result.
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; started_d = started_q;
    ovalid_d = ovalid_q; func_d = func_q; want_d = want_q; rel_d = rel_q;
    idx_d = idx_q; ptr_d = ptr_q; hit_d = hit_q; nxt_d = nxt_q;
    phase_d = phase_q; addr_d = addr_q; st_d = st_q;
    we = 1'b0; waddr = ptr_q[IdxW-1:0]; wdata = hit_q;
    raddr = ptr_q[IdxW-1:0];
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          func_d = s_axis_tuser;
          want_d = want_calc[31:0];
          rel_d  = s_axis_tdata[95:32];
          addr_d = 64'd0;
          ptr_d  = '0;
          state_d = S_SCAN_RD;
          // Large requests never fit in a 32-bit segment.
          if (s_axis_tuser == FuncAlloc && want_calc[32]) want_d = 32'hFFFF_FFFF;
          if (!started_q) begin
            started_d = 1'b1;
            if (span < 32'(HeaderBytes)) begin
              cnt_d = '0;
            end else begin
              we = 1'b1; waddr = '0;
              wdata = '{offset: 32'd0, size: span - 32'(HeaderBytes), used: 1'b0};
              cnt_d = CntW'(1);
            end
          end
        end
      end
      S_SCAN_RD: begin
        raddr = ptr_q[IdxW-1:0];
        if (ptr_q >= cnt_q) begin
          st_d = (func_q == FuncAlloc) ? StNoSpace : StBadFree;
          state_d = S_DONE;
        end else state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        idx_d = ptr_q[IdxW-1:0];
        hit_d = rdata;
        state_d = S_SCAN_RD;
        ptr_d = ptr_q + 1'b1;
        if (func_q == FuncAlloc) begin
          if (!rdata.used && !(want_calc[32] && 1'b0) && rdata.size >= want_q
              && !(want_q == 32'hFFFF_FFFF && rdata.size != 32'hFFFF_FFFF)) begin
            st_d = StOk;
            addr_d = paddr;
            hit_d.used = 1'b1;
            if (rest != 32'd0 && rest >= 32'(HeaderBytes)) begin
              if (cnt_q >= CntW'(MaxSegments)) begin
                st_d = StFull; addr_d = 64'd0; state_d = S_DONE;
              end else begin
                hit_d.size = want_q;
                nxt_d = '{offset: rdata.offset + 32'(HeaderBytes) + want_q,
                          size: rest - 32'(HeaderBytes), used: 1'b0};
                ptr_d = cnt_q;   // shift from the top down
                state_d = S_SHIFT_RD;
              end
            end else begin
              ptr_d = CntW'(ptr_q[IdxW-1:0]);
              state_d = S_FIX;
            end
          end
        end else if (rdata.used && paddr == rel_q) begin
          st_d = StOk;
          hit_d.used = 1'b0;
          phase_d = 2'd0;
          state_d = S_NBR_RD;
        end
      end
      S_SHIFT_RD: begin
        // Move entry ptr-1 to ptr while above idx+1.
        if (ptr_q > CntW'(idx_q) + 1'b1) begin
          raddr = IdxW'(ptr_q - 1'b1);
          state_d = S_SHIFT_WR;
        end else begin
          we = 1'b1; waddr = IdxW'(CntW'(idx_q) + 1'b1); wdata = nxt_q;
          cnt_d = cnt_q + 1'b1;
          ptr_d = CntW'(idx_q);
          state_d = S_FIX;
        end
      end
      S_SHIFT_WR: begin
        we = 1'b1; waddr = ptr_q[IdxW-1:0]; wdata = rdata;
        ptr_d = ptr_q - 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_FIX: begin
        we = 1'b1; waddr = idx_q; wdata = hit_q;
        state_d = S_DONE;
      end
      S_NBR_RD: begin
        // Phase 0 reads the right neighbour, phase 1 the left one.
        if (phase_q == 2'd0) begin
          if (CntW'(idx_q) + 1'b1 < cnt_q) begin
            raddr = idx_q + 1'b1; state_d = S_NBR_CHK;
          end else phase_d = 2'd1;
        end else begin
          if (idx_q != '0) begin
            raddr = idx_q - 1'b1; state_d = S_NBR_CHK;
          end else begin
            ptr_d = CntW'(idx_q); state_d = S_FIX;
          end
        end
      end
      S_NBR_CHK: begin
        if (phase_q == 2'd0) begin
          phase_d = 2'd1;
          state_d = S_NBR_RD;
          if (!rdata.used) begin
            hit_d.size = hit_q.size + 32'(HeaderBytes) + rdata.size;
            ptr_d = CntW'(idx_q) + 2'd2;   // remove idx+1
            state_d = S_REM_RD;
          end
        end else begin
          state_d = S_FIX;
          if (!rdata.used) begin
            nxt_d = rdata;
            hit_d = rdata;
            hit_d.size = rdata.size + 32'(HeaderBytes) + hit_q.size;
            ptr_d = CntW'(idx_q) + 1'b1;   // remove idx
            idx_d = idx_q - 1'b1;
            phase_d = 2'd2;
            state_d = S_REM_RD;
          end
        end
      end
      S_REM_RD: begin
        if (ptr_q < cnt_q) begin
          raddr = ptr_q[IdxW-1:0];
          state_d = S_REM_WR;
        end else begin
          cnt_d = cnt_q - 1'b1;
          state_d = (phase_q == 2'd2) ? S_FIX : S_NBR_RD;
          phase_d = (phase_q == 2'd2) ? 2'd2 : 2'd1;
        end
      end
      S_REM_WR: begin
        we = 1'b1; waddr = IdxW'(ptr_q - 1'b1); wdata = rdata;
        ptr_d = ptr_q + 1'b1;
        state_d = S_REM_RD;
      end
      S_DONE: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* design/ffha_checker.sv */
// Port-level checks for the first-fit heap allocator, bound to the top
// level. Depends on ffha_pkg for status codes.
module ffha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  import ffha_pkg::*;

  // No new request is taken while a result waits.
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept with result pending");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");

  // A failed request grants no address.
  a_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[65:64] != StOk |-> m_axis_tdata[63:0] == 64'd0)
    else $error("address on failure");

  // An accepted request blocks the input in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second accept");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

/* test/tb.sv */
// Self-checking testbench for first_fit_heap_allocator_unit: directed table
// then random allocate/free traffic, checked against an in-bench predictor.
// Depends on ffha_pkg and the allocator RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_index_i = CfgBase;
  logic [63:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // tdata: request_bytes [31:0], release_address [95:32]
  logic [95:0]  s_axis_tdata = '0;
  // tuser: func [0]
  logic         s_axis_tuser = FuncAlloc;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // tdata: granted_address [63:0], status [65:64], zero fill [71:66]
  logic [71:0]  m_axis_tdata;

  first_fit_heap_allocator_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic [63:0] addr;
    logic [1:0]  status;
  } grant_t;

  // Predictor copy of the segment table and heap bounds.
  logic [31:0] seg_off [MaxSegments];
  logic [31:0] seg_size [MaxSegments];
  logic        seg_used [MaxSegments];
  int unsigned seg_cnt;
  bit          heap_live;
  logic [63:0] heap_base_q;
  logic [63:0] heap_limit_q;

  grant_t      pending_grants[$];
  int unsigned mismatches;
  int unsigned status_seen [4];
  bit          quiet_tail;

  function automatic logic [63:0] payload_at(int unsigned i);
    return heap_base_q + 64'(seg_off[i]) + 64'(HeaderBytes);
  endfunction

  function automatic void heap_open();
    logic [63:0] span;
    span = (heap_limit_q > heap_base_q) ? heap_limit_q - heap_base_q : 64'd0;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    heap_live = 1'b1;
    seg_cnt = 0;
    if (span >= 64'(HeaderBytes)) begin
      seg_off[0]  = '0;
      seg_size[0] = 32'(span - 64'(HeaderBytes));
      seg_used[0] = 1'b0;
      seg_cnt     = 1;
    end
  endfunction

  function automatic void drop_entry(int unsigned at);
    for (int unsigned k = at; k + 1 < seg_cnt; k++) begin
      seg_off[k]  = seg_off[k+1];
      seg_size[k] = seg_size[k+1];
      seg_used[k] = seg_used[k+1];
    end
    seg_cnt--;
  endfunction

  // First fit: split only when the remainder can hold a header.
  function automatic grant_t heap_alloc(logic [31:0] bytes);
    grant_t      g;
    logic [63:0] want;
    logic [63:0] rest;
    bit          found;
    want  = ((64'(bytes) + BlockBytes - 1) / BlockBytes) * BlockBytes;
    g     = '{addr: '0, status: StNoSpace};
    found = 1'b0;
    for (int unsigned i = 0; i < seg_cnt; i++) begin
      if (!found && !seg_used[i] && 64'(seg_size[i]) >= want) begin
        found = 1'b1;
        rest  = 64'(seg_size[i]) - want;
        if (rest != 0 && rest >= 64'(HeaderBytes) && seg_cnt >= MaxSegments) begin
          g.status = StFull;
        end else begin
          if (rest != 0 && rest >= 64'(HeaderBytes)) begin
            for (int unsigned k = seg_cnt; k > i + 1; k--) begin
              seg_off[k]  = seg_off[k-1];
              seg_size[k] = seg_size[k-1];
              seg_used[k] = seg_used[k-1];
            end
            seg_off[i+1]  = 32'(64'(seg_off[i]) + 64'(HeaderBytes) + want);
            seg_size[i+1] = 32'(rest - 64'(HeaderBytes));
            seg_used[i+1] = 1'b0;
            seg_cnt++;
            seg_size[i] = 32'(want);
          end
          seg_used[i] = 1'b1;
          g = '{addr: payload_at(i), status: StOk};
        end
      end
    end
    return g;
  endfunction

  // Release a used segment and merge it with free neighbors.
  function automatic grant_t heap_release(logic [63:0] where);
    int unsigned i;
    i = seg_cnt;
    for (int unsigned j = seg_cnt; j > 0; j--)
      if (seg_used[j-1] && payload_at(j-1) == where) i = j - 1;
    if (i >= seg_cnt) return '{addr: '0, status: StBadFree};
    seg_used[i] = 1'b0;
    if (i + 1 < seg_cnt && !seg_used[i+1]) begin
      seg_size[i] = 32'(64'(seg_size[i]) + 64'(HeaderBytes) + 64'(seg_size[i+1]));
      drop_entry(i + 1);
    end
    if (i > 0 && !seg_used[i-1]) begin
      seg_size[i-1] = 32'(64'(seg_size[i-1]) + 64'(HeaderBytes) + 64'(seg_size[i]));
      drop_entry(i);
    end
    return '{addr: '0, status: StOk};
  endfunction

  function automatic grant_t heap_step(logic func, logic [31:0] bytes, logic [63:0] where);
    if (!heap_live) heap_open();
    return (func == FuncAlloc) ? heap_alloc(bytes) : heap_release(where);
  endfunction

  // Present one request and hold it until accepted; the prediction is made
  // at the accepting edge. A typed expectation overrides the predictor.
  task automatic send_request(logic func, logic [31:0] bytes, logic [63:0] where,
                              bit typed, grant_t typed_grant);
    grant_t g;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {where, bytes};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    g = heap_step(func, bytes, where);
    pending_grants.push_back(typed ? typed_grant : g);
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    if (idx == CfgBase) heap_base_q = value;
    else heap_limit_q = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed traffic: small allocates and frees of live segments.
  task automatic random_requests(int unsigned n, bit pause_once);
    int unsigned pick;
    int unsigned used_idx [$];
    for (int unsigned it = 0; it < n; it++) begin
      if (pause_once && it == n / 2) drain_and_settle();
      pick = $urandom_range(0, 99);
      used_idx.delete();
      for (int unsigned j = 0; j < seg_cnt; j++) if (seg_used[j]) used_idx.push_back(j);
      if (pick < 60) begin
        send_request(FuncAlloc, $urandom_range(0, 300), {$urandom, $urandom}, 1'b0, '0);
      end else if (pick < 68) begin
        send_request(FuncAlloc, $urandom, {$urandom, $urandom}, 1'b0, '0);
      end else if (pick < 93 && used_idx.size() != 0) begin
        send_request(FuncFree, $urandom,
                     payload_at(used_idx[$urandom_range(0, used_idx.size() - 1)]),
                     1'b0, '0);
      end else begin
        send_request(FuncFree, $urandom, {$urandom, $urandom}, 1'b0, '0);
      end
    end
  endtask

  typedef struct {
    logic        func;
    logic [31:0] bytes;
    logic [63:0] where;
    bit          typed;
    grant_t      grant;
  } stim_row_t;

  // Directed rows at base 0 with the span saturated to 2^32-1.
  stim_row_t directed_rows [] = '{
    '{FuncFree,  32'd0,          64'd0,          1'b1, '{64'd0,  StBadFree}},
    '{FuncAlloc, 32'd0,          64'd0,          1'b1, '{64'd24, StOk}},
    '{FuncAlloc, 32'hFFFF_FFFF,  64'd0,          1'b1, '{64'd0,  StNoSpace}},
    '{FuncAlloc, 32'd1,          64'd0,          1'b0, '0},
    '{FuncAlloc, 32'd64,         64'd0,          1'b0, '0},
    '{FuncAlloc, 32'd65,         64'd0,          1'b0, '0},
    // Free with both neighbors used, then a second free of the same address.
    '{FuncFree,  32'd0,          64'd136,        1'b0, '0},
    '{FuncFree,  32'd0,          64'd136,        1'b0, '0},
    // Merges toward the next segment, then on both sides.
    '{FuncFree,  32'd0,          64'd48,         1'b0, '0},
    '{FuncFree,  32'd0,          64'd24,         1'b0, '0},
    '{FuncFree,  32'd0,          64'd224,        1'b0, '0},
    // Near-whole heap, then a zero request taking an unsplittable remainder.
    '{FuncAlloc, 32'hFFFF_FFC0,  64'd0,          1'b0, '0},
    '{FuncAlloc, 32'd1,          64'd0,          1'b0, '0},
    '{FuncAlloc, 32'd0,          64'd0,          1'b0, '0},
    '{FuncFree,  32'd0,          64'd24,         1'b0, '0},
    '{FuncFree,  32'd0,          64'd4294967280, 1'b0, '0},
    '{FuncFree,  32'hFFFF_FFFF,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{FuncFree,  32'd0,          64'd1,          1'b0, '0}
  };

  // Receiver side: random stall bursts until the tail of the run.
  initial begin
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    grant_t exp_g;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        exp_g = pending_grants.pop_front();
        status_seen[m_axis_tdata[65:64]]++;
        if (m_axis_tdata[63:0] !== exp_g.addr || m_axis_tdata[65:64] !== exp_g.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                     exp_g.addr, exp_g.status, m_axis_tdata[63:0], m_axis_tdata[65:64]);
        end
      end
    end
  end

  initial begin
    heap_base_q  = 64'd0;
    heap_limit_q = 64'd1048576;
    seg_cnt      = 0;
    heap_live    = 1'b0;
    mismatches   = 0;
    quiet_tail   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Widest possible span before the table is built.
    write_cfg(CfgBase, 64'd0);
    write_cfg(CfgLimit, 64'hFFFF_FFFF_FFFF_FFFF);
    foreach (directed_rows[r])
      send_request(directed_rows[r].func, directed_rows[r].bytes, directed_rows[r].where,
                   directed_rows[r].typed, directed_rows[r].grant);
    random_requests(600, 1'b1);
    drain_and_settle();
    // Base near the top of the address space so addresses wrap.
    write_cfg(CfgBase, 64'hFFFF_FFFF_FFFF_FFC0);
    write_cfg(CfgLimit, 64'd0);
    random_requests(600, 1'b0);
    drain_and_settle();
    write_cfg(CfgBase, {$urandom, $urandom});
    write_cfg(CfgLimit, {$urandom, $urandom});
    random_requests(400, 1'b0);
    quiet_tail = 1'b1;
    random_requests(300, 1'b0);
    drain_and_settle();
    if (pending_grants.size() != 0) mismatches++;
    $display("Ran %0d directed and 1900 random requests over three heap base settings.",
             directed_rows.size());
    $display("Statuses seen: ok %0d, no space %0d, bad free %0d, table full %0d.",
             status_seen[StOk], status_seen[StNoSpace], status_seen[StBadFree],
             status_seen[StFull]);
    if (mismatches == 0) begin
      $display("first_fit_heap_allocator_unit verification clean");
    end else begin
      $display("first_fit_heap_allocator_unit verification failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("first_fit_heap_allocator_unit verification failed");
    $finish;
  end

endmodule
